// ===== hw/rtl/zpf_pkg.sv =====
`timescale 1ns / 1ps

package zpf_pkg;

    localparam int MAX_LEN  = 64;
    localparam int PAD_LEN  = 6;
    localparam int WORK_LEN = MAX_LEN + 2 * PAD_LEN;

    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 18;
    localparam int WORK_W   = 24;
    localparam int CNT_W    = $clog2(MAX_LEN + 1);
    localparam int IDX_W    = $clog2(MAX_LEN);
    localparam int WADDR_W  = $clog2(WORK_LEN);
    localparam int LEN_W    = $clog2(WORK_LEN + 1);
    localparam int PAD_W    = $clog2(PAD_LEN + 1);

    localparam logic [1:0] CFG_B0   = 2'd0;
    localparam logic [1:0] CFG_B1   = 2'd1;
    localparam logic [1:0] CFG_A1   = 2'd2;
    localparam logic [1:0] CFG_INIT = 2'd3;

    localparam logic signed [COEF_W-1:0] B0_RESET   = 18'sd8961;
    localparam logic signed [COEF_W-1:0] B1_RESET   = 18'sd8961;
    localparam logic signed [COEF_W-1:0] A1_RESET   = -18'sd47615;
    localparam logic signed [COEF_W-1:0] INIT_RESET = 18'sd56575;

    // One collected block waiting for the filter engine.
    typedef struct packed {
        logic             bank;
        logic [CNT_W-1:0] n;
        logic             ovf;
    } zpf_desc_t;

    typedef struct packed {
        logic      push;
        logic      pop;
        zpf_desc_t data;
    } zpf_qctl_t;

    typedef struct packed {
        logic      full;
        logic      empty;
        zpf_desc_t head;
    } zpf_qstat_t;

endpackage

// ===== hw/rtl/zero_phase_iir_filter.sv =====
`timescale 1ns / 1ps
// Channel   Signals                                   Direction
// in        in_valid, in_ready, sample_in, last_in    request in
// out       out_valid, out_ready, sample_out,         request out
//           last_out, overflowed
// cfg       cfg_valid, cfg_ready, cfg_index, cfg_data request in
//
// Samples are taken one per cycle while the two-deep block queue has room;
// two input banks let the next block load while one is filtered.
// The engine loads the padded block, then runs the two filter passes over it,
// forward then reverse (one shared multiplier, three products per element),
// and then sends the results out.
// Reset clears control state and restores the coefficient defaults.
// A stalled output holds its request; the engine waits, the front keeps loading.

module zero_phase_iir_filter
    import zpf_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic signed [SAMPLE_W-1:0] sample_in,
    input  logic                       last_in,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [SAMPLE_W-1:0] sample_out,
    output logic                       last_out,
    output logic                       overflowed,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [1:0]                 cfg_index,
    input  logic [COEF_W-1:0]          cfg_data
);

    zpf_qctl_t  q_ctl;
    zpf_qstat_t q_stat;
    logic [IDX_W:0]             in_addr;
    logic signed [SAMPLE_W-1:0] in_data;

    assign cfg_ready = 1'b1;

    zpf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .sample_in (sample_in),
        .last_in   (last_in),
        .q_full    (q_stat.full),
        .q_push    (q_ctl.push),
        .q_data    (q_ctl.data),
        .rd_addr   (in_addr),
        .rd_data   (in_data)
    );

    zpf_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (q_ctl),
        .stat  (q_stat)
    );

    zpf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .q_stat     (q_stat),
        .q_pop      (q_ctl.pop),
        .in_addr    (in_addr),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .sample_out (sample_out),
        .last_out   (last_out),
        .overflowed (overflowed)
    );

endmodule

// ===== hw/rtl/zpf_queue.sv =====
`timescale 1ns / 1ps

module zpf_queue
    import zpf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  zpf_qctl_t  ctl,
    output zpf_qstat_t stat
);

    zpf_desc_t   slot_reg [2];
    logic        rd_ptr_reg;
    logic        wr_ptr_reg;
    logic [1:0]  count_reg;

    assign stat.full  = (count_reg == 2'd2);
    assign stat.empty = (count_reg == 2'd0);
    assign stat.head  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (ctl.push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (ctl.pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (ctl.push && !ctl.pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (ctl.pop && !ctl.push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.push)
        begin
            slot_reg[wr_ptr_reg] <= ctl.data;
        end
    end

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.push && stat.full |-> ctl.pop)
        else $error("block queue overrun");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.pop |-> !stat.empty)
        else $error("block queue underrun");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("block queue count out of range");
`endif

endmodule

// ===== hw/rtl/zpf_front.sv =====
`timescale 1ns / 1ps

module zpf_front
    import zpf_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic signed [SAMPLE_W-1:0] sample_in,
    input  logic                       last_in,
    input  logic                       q_full,
    output logic                       q_push,
    output zpf_desc_t                  q_data,
    input  logic [IDX_W:0]             rd_addr,
    output logic signed [SAMPLE_W-1:0] rd_data
);

    // Two banks: one block fills while the engine works on the other.
    logic signed [SAMPLE_W-1:0] mem [2 * MAX_LEN];

    logic             bank_reg;
    logic [CNT_W-1:0] count_reg;
    logic             ovf_reg;
    logic             accept;
    logic             room;
    logic [CNT_W-1:0] count_next;
    logic             ovf_next;

    assign in_ready   = !q_full;
    assign accept     = in_valid && in_ready;
    assign room       = (count_reg < CNT_W'(MAX_LEN));
    assign count_next = room ? count_reg + CNT_W'(1) : count_reg;
    assign ovf_next   = ovf_reg || !room;

    assign q_push      = accept && last_in;
    assign q_data.bank = bank_reg;
    assign q_data.n    = count_next;
    assign q_data.ovf  = ovf_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_reg  <= 1'b0;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (accept)
        begin
            if (last_in)
            begin
                bank_reg  <= ~bank_reg;
                count_reg <= '0;
                ovf_reg   <= 1'b0;
            end
            else
            begin
                count_reg <= count_next;
                ovf_reg   <= ovf_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && room)
        begin
            mem[{bank_reg, count_reg[IDX_W-1:0]}] <= sample_in;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== hw/rtl/zpf_back.sv =====
`timescale 1ns / 1ps

module zpf_back
    import zpf_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [1:0]                 cfg_index,
    input  logic [COEF_W-1:0]          cfg_data,
    input  zpf_qstat_t                 q_stat,
    output logic                       q_pop,
    output logic [IDX_W:0]             in_addr,
    input  logic signed [SAMPLE_W-1:0] in_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [SAMPLE_W-1:0] sample_out,
    output logic                       last_out,
    output logic                       overflowed
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_LD_X0, ST_LD_XL, ST_LD_XLC, ST_LD_RD, ST_LD_WR,
        ST_F_RD, ST_F_M0, ST_F_M1, ST_F_M2, ST_F_WR, ST_O_RD, ST_O_WAIT, ST_DONE
    } state_t;

    localparam int PROD_W = COEF_W + WORK_W + 1;
    localparam int TERM_W = PROD_W - 16;
    localparam int ACC_W  = TERM_W + 2;

    state_t state_reg;
    logic signed [COEF_W-1:0] b0_reg, b1_reg, a1_reg, init_reg;
    logic [LEN_W-1:0]         k_reg;
    logic                     rev_reg;
    logic signed [SAMPLE_W-1:0] x0_reg, xl_reg;
    logic signed [WORK_W-1:0] x_reg, px_reg, py_reg;
    logic signed [TERM_W-1:0] term_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic                     out_valid_reg;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic                     last_reg;
    logic                     ovf_reg;

    logic signed [WORK_W-1:0] wmem [WORK_LEN];
    logic signed [WORK_W-1:0] wrdata;
    logic                     w_re, w_we;
    logic [WADDR_W-1:0]       w_raddr, w_waddr;
    logic signed [WORK_W-1:0] w_wdata;

    logic [CNT_W-1:0] n;
    logic [PAD_W-1:0] p;
    logic [LEN_W-1:0] len;
    logic             k_first;
    logic [LEN_W-1:0] pidx;
    logic [7:0]       j8, p8, n8, lidx;
    logic             in_pre, in_mid;
    logic signed [WORK_W-1:0] r_e, x0_e, xl_e, lval;

    logic signed [COEF_W-1:0] mul_a;
    logic signed [WORK_W-1:0] mul_b;
    logic signed [PROD_W-1:0] prod;
    logic signed [TERM_W-1:0] rnd;
    logic signed [ACC_W-1:0]  ysum;
    logic signed [WORK_W-1:0] ysat;
    logic signed [SAMPLE_W-1:0] osat;

    assign n       = q_stat.head.n;
    assign p       = (n > CNT_W'(PAD_LEN)) ? PAD_W'(PAD_LEN) : PAD_W'(n - CNT_W'(1));
    assign len     = LEN_W'(n) + LEN_W'({p, 1'b0});
    assign k_first = (k_reg == '0);
    assign pidx    = rev_reg ? len - LEN_W'(1) - k_reg : k_reg;

    // Padded-block index j maps back to a stored sample.
    assign j8     = 8'(k_reg);
    assign p8     = 8'(p);
    assign n8     = 8'(n);
    assign in_pre = (j8 < p8);
    assign in_mid = (j8 < p8 + n8);
    always_comb
    begin
        if (in_pre)
        begin
            lidx = p8 - j8;
        end
        else if (in_mid)
        begin
            lidx = j8 - p8;
        end
        else
        begin
            lidx = (n8 << 1) + p8 - 8'd2 - j8;
        end
    end

    assign r_e  = WORK_W'(in_data);
    assign x0_e = WORK_W'(x0_reg);
    assign xl_e = WORK_W'(xl_reg);
    assign lval = in_pre ? (x0_e <<< 1) - r_e : (in_mid ? r_e : (xl_e <<< 1) - r_e);

    always_comb
    begin
        unique case (state_reg)
            ST_LD_X0: in_addr = {q_stat.head.bank, IDX_W'(0)};
            ST_LD_XL: in_addr = {q_stat.head.bank, IDX_W'(n - CNT_W'(1))};
            default:  in_addr = {q_stat.head.bank, lidx[IDX_W-1:0]};
        endcase
    end

    always_comb
    begin
        unique case (state_reg)
            ST_F_M0:
            begin
                mul_a = b0_reg;
                mul_b = wrdata;
            end
            ST_F_M1:
            begin
                mul_a = k_first ? init_reg : b1_reg;
                mul_b = k_first ? x_reg : px_reg;
            end
            default:
            begin
                mul_a = a1_reg;
                mul_b = py_reg;
            end
        endcase
    end

    // Product rounded to an integer: add one half, then floor shift by 16.
    assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);
    always_comb
    begin
        logic signed [PROD_W-1:0] biased;
        biased = prod + PROD_W'(32768);
        rnd    = biased[PROD_W-1:16];
    end

    assign ysum = acc_reg + ACC_W'(term_reg);
    assign ysat = (ysum > ACC_W'(8388607)) ? 24'sh7FFFFF :
                  (ysum < -ACC_W'(8388608)) ? 24'sh800000 : ysum[WORK_W-1:0];
    assign osat = (wrdata > 24'sd32767) ? 16'sh7FFF :
                  (wrdata < -24'sd32768) ? 16'sh8000 : wrdata[SAMPLE_W-1:0];

    assign w_re    = (state_reg == ST_F_RD) || (state_reg == ST_O_RD);
    assign w_raddr = (state_reg == ST_O_RD) ? WADDR_W'(LEN_W'(p) + k_reg) : WADDR_W'(pidx);
    assign w_we    = (state_reg == ST_LD_WR) || (state_reg == ST_F_WR);
    assign w_waddr = WADDR_W'(pidx);
    assign w_wdata = (state_reg == ST_LD_WR) ? lval : ysat;

    always_ff @(posedge clk)
    begin
        if (w_we)
        begin
            wmem[w_waddr] <= w_wdata;
        end
        if (w_re)
        begin
            wrdata <= wmem[w_raddr];
        end
    end

    assign q_pop      = (state_reg == ST_DONE);
    assign out_valid  = out_valid_reg;
    assign sample_out = sample_reg;
    assign last_out   = last_reg;
    assign overflowed = ovf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            b0_reg        <= B0_RESET;
            b1_reg        <= B1_RESET;
            a1_reg        <= A1_RESET;
            init_reg      <= INIT_RESET;
            k_reg         <= '0;
            rev_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_B0:   b0_reg   <= cfg_data;
                    CFG_B1:   b1_reg   <= cfg_data;
                    CFG_A1:   a1_reg   <= cfg_data;
                    CFG_INIT: init_reg <= cfg_data;
                    default:  ;
                endcase
            end
            // The result register refills in ST_O_WAIT; elsewhere an accepted request clears it.
            if (out_valid_reg && out_ready && (state_reg != ST_O_WAIT))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    k_reg   <= '0;
                    rev_reg <= 1'b0;
                    if (!q_stat.empty)
                    begin
                        state_reg <= ST_LD_X0;
                    end
                end
                ST_LD_X0:  state_reg <= ST_LD_XL;
                ST_LD_XL:
                begin
                    x0_reg    <= in_data;
                    state_reg <= ST_LD_XLC;
                end
                ST_LD_XLC:
                begin
                    xl_reg    <= in_data;
                    state_reg <= ST_LD_RD;
                end
                ST_LD_RD:  state_reg <= ST_LD_WR;
                ST_LD_WR:
                begin
                    if (k_reg == len - LEN_W'(1))
                    begin
                        k_reg     <= '0;
                        state_reg <= ST_F_RD;
                    end
                    else
                    begin
                        k_reg     <= k_reg + LEN_W'(1);
                        state_reg <= ST_LD_RD;
                    end
                end
                ST_F_RD:   state_reg <= ST_F_M0;
                ST_F_M0:
                begin
                    x_reg     <= wrdata;
                    term_reg  <= rnd;
                    acc_reg   <= '0;
                    state_reg <= ST_F_M1;
                end
                ST_F_M1:
                begin
                    term_reg  <= rnd;
                    acc_reg   <= acc_reg + ACC_W'(term_reg);
                    state_reg <= ST_F_M2;
                end
                ST_F_M2:
                begin
                    term_reg  <= k_first ? '0 : -rnd;
                    acc_reg   <= acc_reg + ACC_W'(term_reg);
                    state_reg <= ST_F_WR;
                end
                ST_F_WR:
                begin
                    px_reg <= x_reg;
                    py_reg <= ysat;
                    if (k_reg == len - LEN_W'(1))
                    begin
                        k_reg <= '0;
                        if (rev_reg)
                        begin
                            state_reg <= ST_O_RD;
                        end
                        else
                        begin
                            rev_reg   <= 1'b1;
                            state_reg <= ST_F_RD;
                        end
                    end
                    else
                    begin
                        k_reg     <= k_reg + LEN_W'(1);
                        state_reg <= ST_F_RD;
                    end
                end
                ST_O_RD:   state_reg <= ST_O_WAIT;
                ST_O_WAIT:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        sample_reg    <= osat;
                        last_reg      <= (k_reg == LEN_W'(n) - LEN_W'(1));
                        ovf_reg       <= q_stat.head.ovf;
                        if (k_reg == LEN_W'(n) - LEN_W'(1))
                        begin
                            state_reg <= ST_DONE;
                        end
                        else
                        begin
                            k_reg     <= k_reg + LEN_W'(1);
                            state_reg <= ST_O_RD;
                        end
                    end
                end
                ST_DONE:   state_reg <= ST_IDLE;
                default:   state_reg <= ST_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_block_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        !q_stat.empty |-> q_stat.head.n != '0)
        else $error("queued block has no samples");
    a_pass_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_F_WR |-> k_reg < len)
        else $error("filter pass index past padded length");
    a_start_after_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE && !q_stat.empty |=> state_reg == ST_LD_X0)
        else $error("pending block not started");
`endif

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

class filtfilt_scoreboard;
    logic signed [17:0] b0, b1, a1, init_gain;
    logic signed [15:0] block_buf[$];
    bit                 dropped;
    logic signed [15:0] exp_sample[$];
    bit                 exp_last[$];
    bit                 exp_ovf[$];
    int                 mismatches;

    function new();
        b0 = 18'sd8961;
        b1 = 18'sd8961;
        a1 = -18'sd47615;
        init_gain = 18'sd56575;
        dropped = 0;
        mismatches = 0;
    endfunction

    function void set_coef(input logic [1:0] idx, input logic [17:0] val);
        case (idx)
            zpf_pkg::CFG_B0:   b0 = val;
            zpf_pkg::CFG_B1:   b1 = val;
            zpf_pkg::CFG_A1:   a1 = val;
            zpf_pkg::CFG_INIT: init_gain = val;
            default: ;
        endcase
    endfunction

    // Product rounded to an integer: add one half, then floor shift.
    function longint round_mul(input longint c, input longint v);
        return (c * v + 32768) >>> 16;
    endfunction

    function longint clamp(input longint v, input longint lo, input longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function void filter_pass(ref longint w[], input int len, input bit rev);
        longint px, py, x, y;
        int i;
        px = 0;
        py = 0;
        for (int k = 0; k < len; k++) begin
            i = rev ? len - 1 - k : k;
            x = w[i];
            if (k == 0)
                y = round_mul(b0, x) + round_mul(init_gain, x);
            else
                y = round_mul(b0, x) + round_mul(b1, px) - round_mul(a1, py);
            y = clamp(y, -8388608, 8388607);
            w[i] = y;
            px = x;
            py = y;
        end
    endfunction

    function void note_sample(input logic signed [15:0] s, input bit last);
        longint w[];
        int n, p, len;
        if (block_buf.size() < zpf_pkg::MAX_LEN)
            block_buf.push_back(s);
        else
            dropped = 1;
        if (!last)
            return;
        n = block_buf.size();
        p = (n > zpf_pkg::PAD_LEN) ? zpf_pkg::PAD_LEN : n - 1;
        len = n + 2 * p;
        w = new[len];
        for (int i = 0; i < p; i++)
            w[i] = 2 * longint'(block_buf[0]) - block_buf[p - i];
        for (int i = 0; i < n; i++)
            w[p + i] = block_buf[i];
        for (int i = 1; i <= p; i++)
            w[n + p + i - 1] = 2 * longint'(block_buf[n - 1]) - block_buf[n - 1 - i];
        filter_pass(w, len, 0);
        filter_pass(w, len, 1);
        for (int i = 0; i < n; i++) begin
            exp_sample.push_back(16'(clamp(w[p + i], -32768, 32767)));
            exp_last.push_back(i == n - 1);
            exp_ovf.push_back(dropped);
        end
        block_buf.delete();
        dropped = 0;
    endfunction

    function void check_result(input logic signed [15:0] s, input bit last,
                               input bit ovf);
        if (exp_sample.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result: sample %0d last %0b ovf %0b", s, last, ovf);
            return;
        end
        if (s !== exp_sample[0] || last !== exp_last[0] || ovf !== exp_ovf[0]) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: expected %0d/%0b/%0b, got %0d/%0b/%0b",
                         exp_sample[0], exp_last[0], exp_ovf[0], s, last, ovf);
        end
        void'(exp_sample.pop_front());
        void'(exp_last.pop_front());
        void'(exp_ovf.pop_front());
    endfunction

    function int pending();
        return exp_sample.size();
    endfunction
endclass

module testbench;
    import zpf_pkg::*;

    localparam int STALL_LIMIT = 20000;

    logic                       clk = 0;
    logic                       rst_n = 0;
    logic                       in_valid = 0;
    logic                       in_ready;
    logic signed [SAMPLE_W-1:0] sample_in = '0;
    logic                       last_in = 0;
    logic                       out_valid;
    logic                       out_ready = 0;
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       last_out;
    logic                       overflowed;
    logic                       cfg_valid = 0;
    logic                       cfg_ready;
    logic [1:0]                 cfg_index = '0;
    logic [COEF_W-1:0]          cfg_data = '0;

    filtfilt_scoreboard sb = new();
    bit  hold_off = 0;
    bit  steady_out = 0;
    int  idle_cycles = 0;

    zero_phase_iir_filter dut (.*);

    always #5 clk = ~clk;

    // Output side: stall pattern of its own, a steady mode, plus a long hold-off on request.
    always @(posedge clk) begin
        if (out_valid && out_ready)
            sb.check_result(sample_out, last_out, overflowed);
        if (hold_off)
            out_ready <= 0;
        else if (steady_out)
            out_ready <= 1;
        else
            out_ready <= ($urandom_range(0, 3) != 0);
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    int burst_left = 0;

    task automatic send_sample(input logic signed [15:0] s, input bit last);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 6);
            repeat (gap) @(posedge clk);
        end
        burst_left--;
        in_valid  <= 1;
        sample_in <= s;
        last_in   <= last;
        do @(posedge clk); while (!in_ready);
        sb.note_sample(s, last);
        // Valid drops only between bursts, before the next request.
        if (burst_left == 0) begin
            in_valid <= 0;
            @(posedge clk);
        end
    endtask

    task automatic send_block(input int n, input int kind);
        logic signed [15:0] s;
        for (int i = 0; i < n; i++) begin
            case (kind)
                0: s = 16'($urandom);
                1: s = (i % 2) ? 16'sh7fff : -16'sh8000;
                2: s = 16'sh7fff;
                3: s = -16'sh8000;
                default: s = $urandom_range(0, 1) ? 16'($urandom_range(0, 400) - 200)
                                                  : 16'($urandom);
            endcase
            send_sample(s, i == n - 1);
        end
    endtask

    task automatic drain();
        in_valid <= 0;
        while (sb.pending() != 0) @(posedge clk);
        // Engine may still be busy after the last result; allow a margin.
        repeat (2000) @(posedge clk);
    endtask

    task automatic write_coef(input logic [1:0] idx, input logic [17:0] val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        sb.set_coef(idx, val);
        cfg_valid <= 0;
        @(posedge clk);
    endtask

    task automatic write_all(input logic [17:0] vb0, input logic [17:0] vb1,
                             input logic [17:0] va1, input logic [17:0] vi);
        write_coef(CFG_B0, vb0);
        write_coef(CFG_B1, vb1);
        write_coef(CFG_A1, va1);
        write_coef(CFG_INIT, vi);
    endtask

    task automatic random_blocks(input int count);
        int n;
        for (int b = 0; b < count; b++) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 70) : $urandom_range(1, 6);
            send_block(n, $urandom_range(0, 4));
        end
    endtask

    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: reset coefficients, extremes, short blocks and a long one.
        send_block(1, 2);
        send_block(2, 3);
        send_block(3, 1);
        send_block(7, 1);
        send_block(8, 0);
        drain();
        write_all(18'h1ffff, 18'h20000, 18'h1ffff, 18'h20000);
        send_block(5, 2);
        send_block(1, 3);
        drain();
        write_all(18'd30000, 18'd30000, -18'sd20000, 18'd0);
        send_block(66, 0);
        drain();

        // The block queue fills up while the output is held off.
        hold_off = 1;
        fork
            begin
                repeat (1500) @(posedge clk);
                hold_off = 0;
            end
            random_blocks(4);
        join
        drain();

        write_all(18'd8961, 18'd8961, -18'sd47615, 18'd56575);
        steady_out = 1;
        random_blocks(3);
        steady_out = 0;
        random_blocks(3);
        drain();
        write_all(18'($urandom), 18'($urandom), 18'($urandom), 18'($urandom));
        random_blocks(3);
        drain();

        while (sb.pending() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
